@@ hdl/cdll_pkg.sv @@
// ----------------------------------------------------------------------------
// cdll_pkg: shared types and constants for the checked decimal list loader
// Character codes, parse limits, result status codes and the parser state
// bundle passed from the parser to the top level.
// ----------------------------------------------------------------------------
package cdll_pkg;

    localparam int VALUE_W        = 32;
    localparam int STATUS_W       = 3;
    localparam int STORED_COUNT_W = 9;
    localparam int CHAR_W         = 8;

    // ASCII codes recognized by the parser
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Largest magnitudes for a positive and a negative token
    localparam logic [VALUE_W+3:0] POS_LIMIT = 36'd2147483647;
    localparam logic [VALUE_W+3:0] NEG_LIMIT = 36'd2147483648;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_HALTED = 3'd4;

    // Token state seen by the control logic
    typedef struct packed {
        logic [VALUE_W-1:0] magnitude;
        logic               negative;
        logic               bad;
    } parse_state_t;

endpackage

@@ hdl/cdll_ram.sv @@
// ----------------------------------------------------------------------------
// cdll_ram: generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cdll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/cdll_parser.sv @@
// ----------------------------------------------------------------------------
// cdll_parser: per-character decimal token parser
// Accumulates the magnitude of a signed decimal token one character per cycle,
// accepts one leading sign and flags non-digits and out-of-range magnitudes.
// ----------------------------------------------------------------------------
module cdll_parser
    import cdll_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic              token_clear,
    input  logic [CHAR_W-1:0] char_code,
    output parse_state_t      parse
);

    logic [VALUE_W-1:0] magnitude_reg, magnitude_next;
    logic               negative_reg, negative_next;
    logic               bad_reg, bad_next;
    logic               at_start_reg, at_start_next;

    logic               is_digit;
    logic               is_sign;
    logic [VALUE_W+3:0] times_ten;
    logic [VALUE_W+3:0] limit;

    // Multiply by ten as two shifts and an add, then add the digit
    assign is_digit  = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign is_sign   = (char_code == CHAR_PLUS) || (char_code == CHAR_MINUS);
    assign times_ten = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                       + {(VALUE_W + 0)'(0), (char_code[3:0] - CHAR_ZERO[3:0])};
    assign limit     = negative_reg ? NEG_LIMIT : POS_LIMIT;

    // Next token state
    always_comb
    begin
        magnitude_next = magnitude_reg;
        negative_next  = negative_reg;
        bad_next       = bad_reg;
        at_start_next  = at_start_reg;
        if (token_clear)
        begin
            magnitude_next = '0;
            negative_next  = 1'b0;
            bad_next       = 1'b0;
            at_start_next  = 1'b1;
        end
        else if (take)
        begin
            at_start_next = 1'b0;
            if (!bad_reg)
            begin
                if (at_start_reg && is_sign)
                begin
                    negative_next = (char_code == CHAR_MINUS);
                end
                else if (is_digit)
                begin
                    if (times_ten > limit)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        magnitude_next = times_ten[VALUE_W-1:0];
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    // Hold token state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnitude_reg <= '0;
            negative_reg  <= 1'b0;
            bad_reg       <= 1'b0;
            at_start_reg  <= 1'b1;
        end
        else
        begin
            magnitude_reg <= magnitude_next;
            negative_reg  <= negative_next;
            bad_reg       <= bad_next;
            at_start_reg  <= at_start_next;
        end
    end

    assign parse.magnitude = magnitude_reg;
    assign parse.negative  = negative_reg;
    assign parse.bad       = bad_reg;

endmodule

@@ hdl/checked_decimal_list_loader_top.sv @@
// ----------------------------------------------------------------------------
// checked_decimal_list_loader_top: decimal token parser with distinct-value table
// Parses signed decimal tokens one ASCII character per transaction and appends
// each new value to a table held in a RAM, halting on the first error.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive char_code, token_last and token_empty with start high; the
//   transaction is taken on a rising edge where start is high and busy is low.
//   A transaction with token_last or token_empty ends the token.
//   Output: one result per finished token, on value, status and stored_count
//   while done is high for exactly one cycle. The receiver cannot stall.
// Timing:
//   A character that does not end a token leaves busy low.
//   A token end is checked and then searched for in the table of stored values,
//   one entry per cycle through the registered read port of the value RAM; a
//   duplicate returns as soon as it is seen. busy is low again in the done cycle.
//   A bad token, and after a halt every token end, returns without a table search.
// Reset:
//   rst_n clears the entry count, the token state and the halt flag. The RAM
//   is not cleared: only entries below the entry count are ever compared.
// ----------------------------------------------------------------------------
module checked_decimal_list_loader_top
    import cdll_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [CHAR_W-1:0]         char_code,
    input  logic                      token_last,
    input  logic                      token_empty,
    output logic                      done,
    output logic signed [VALUE_W-1:0] value,
    output logic [STATUS_W-1:0]       status,
    output logic [STORED_COUNT_W-1:0] stored_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_COUNT = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       entry_count_reg, entry_count_next;
    logic                halted_reg, halted_next;
    logic                done_reg, done_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [VALUE_W-1:0]  value_out_reg, value_out_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                accept;
    logic                char_take;
    logic                token_end;
    logic                token_clear;
    parse_state_t        parse;

    logic                ram_we;
    logic [VALUE_W-1:0]  ram_rdata;
    logic                hit;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign char_take = accept && !token_empty && !halted_reg;
    assign token_end = accept && (token_last || token_empty);
    assign hit       = pend_reg && (ram_rdata == value_reg);

    cdll_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (char_take),
        .token_clear (token_clear),
        .char_code   (char_code),
        .parse       (parse)
    );

    // Value table; a read of the entry being written is never compared
    cdll_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_count_reg[AW-1:0]),
        .wdata (value_reg),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Control: check the token, search the table, then store or report
    always_comb
    begin
        state_next       = state_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = pend_reg;
        entry_count_next = entry_count_reg;
        halted_next      = halted_reg;
        done_next        = 1'b0;
        value_next       = value_reg;
        value_out_next   = value_out_reg;
        status_next      = status_reg;
        token_clear      = 1'b0;
        ram_we           = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (token_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                token_clear = 1'b1;
                if (halted_reg)
                begin
                    done_next      = 1'b1;
                    value_out_next = '0;
                    status_next    = ST_HALTED;
                    state_next     = S_IDLE;
                end
                else if (parse.bad)
                begin
                    done_next      = 1'b1;
                    value_out_next = '0;
                    status_next    = ST_BAD;
                    halted_next    = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    value_next  = parse.negative ? (VALUE_W'(0) - parse.magnitude)
                                                 : parse.magnitude;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    done_next      = 1'b1;
                    value_out_next = value_reg;
                    status_next    = ST_DUP;
                    halted_next    = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
                else if (rd_idx_reg < entry_count_reg)
                begin
                    // Issue the next read; its data is compared next cycle
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    done_next      = 1'b1;
                    value_out_next = value_reg;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                    if (entry_count_reg == DEPTH_COUNT)
                    begin
                        status_next = ST_FULL;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        ram_we           = 1'b1;
                        entry_count_next = entry_count_reg + CW'(1);
                        status_next      = ST_STORED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rd_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            entry_count_reg <= '0;
            halted_reg      <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            pend_reg        <= pend_next;
            entry_count_reg <= entry_count_next;
            halted_reg      <= halted_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
    end

    assign done         = done_reg;
    assign value        = value_out_reg;
    assign status       = status_reg;
    assign stored_count = STORED_COUNT_W'(entry_count_reg);

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the block is busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= DEPTH_COUNT)
        else $error("entry count beyond table depth");

    a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (rd_idx_reg <= entry_count_reg))
        else $error("table read beyond stored entries");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_BAD || status == ST_HALTED)) |-> (value == '0))
        else $error("nonzero value with an error status");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt cleared without reset");

endmodule
